@@ design/assert_macros.svh @@
// Assertion helpers included by the frame average top-level module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define TFA_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("frame average: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define TFA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame average: same-cycle implication violated");

// Consequent must hold in the cycle after the antecedent.
`define TFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame average: next-cycle implication violated");

`endif

@@ design/tfa_pkg.sv @@
`default_nettype none

package tfa_pkg;

    // Field and state widths.
    localparam int BYTE_W      = 8;
    localparam int SUM_W       = 16;
    localparam int ACC_W       = SUM_W + 1;
    localparam int CNT_W       = 8;
    localparam int FB_W        = 21;
    localparam int CFG_W       = 21;
    localparam int CFG_IDX_W   = 2;

    // Reciprocal divider: floor(2^RECIP_SHIFT / d) with a one-step correction.
    localparam int RECIP_SHIFT = ACC_W;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int RECIP_ONE   = 2 ** RECIP_SHIFT;
    localparam int PROD_W      = ACC_W + RECIP_W;
    localparam int RECIP_DEPTH = 2 ** CNT_W;

    // Saturation limits.
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [BYTE_W-1:0] BYTE_MAX = '1;
    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;

    // Register reset values.
    localparam logic [FB_W-1:0]  FRAME_BYTES_RST = 21'd691200;
    localparam logic [CNT_W-1:0] MAX_FRAMES_RST  = 8'd180;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_BYTES = 2'd0,
        CFG_MAX_FRAMES  = 2'd1,
        CFG_PASSTHROUGH = 2'd2
    } t_cfg_idx;

endpackage

`default_nettype wire

@@ design/temporal_frame_average_unit.sv @@
`default_nettype none
// Temporal frame averaging of a byte stream.
// Input stream (s_axis): one video byte per request in tdata. Output stream
// (m_axis): the averaged byte in tdata, with tlast high on the last byte of
// each frame. Every accepted input byte produces exactly one output byte.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_wdata while
// the stream is idle: 0 = frame size in bytes, 1 = frame count cap,
// 2 = passthrough.
// Throughput is one byte per cycle while the receiver keeps tready high and
// the first four stages hold no earlier byte of the same frame position,
// which is always true for frames of five or more bytes; shorter frames wait
// for the earlier write-back of their position's running sum. Division uses
// a reciprocal table and two registered multiplies, so it never limits the
// rate.
// After reset all MAX_FRAME_BYTES entries of the running-sum memory are swept
// to zero, one entry per cycle; s_axis_tready stays low meanwhile.
// When the receiver stalls, the output register holds its request and the
// pipeline keeps filling its empty stages before tready drops.

module temporal_frame_average_unit
    import tfa_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 1048576
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Configuration write port.
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    // Input stream.
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [BYTE_W-1:0]    s_axis_tdata,   // [7:0] pixel_byte
    // Output stream.
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [BYTE_W-1:0]    m_axis_tdata,   // [7:0] average_byte
    output logic                      m_axis_tlast    // frame_end
);

    `include "assert_macros.svh"

    localparam int PW = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
    localparam int SW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CW = (SW > FB_W) ? SW : FB_W;

    // Configuration registers.
    logic [FB_W-1:0]  r_frame_bytes;
    logic [CNT_W-1:0] r_max_frames;
    logic             r_passthrough;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_bytes <= FRAME_BYTES_RST;
            r_max_frames  <= MAX_FRAMES_RST;
            r_passthrough <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FRAME_BYTES: r_frame_bytes <= i_cfg_wdata[FB_W-1:0];
                CFG_MAX_FRAMES:  r_max_frames  <= i_cfg_wdata[CNT_W-1:0];
                CFG_PASSTHROUGH: r_passthrough <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Reciprocal table, one entry per divisor value.
    logic [RECIP_W-1:0] w_recip [RECIP_DEPTH];

    for (genvar gi = 0; gi < RECIP_DEPTH; gi++) begin : g_recip
        localparam int unsigned RV = (gi == 0) ? 0 : RECIP_ONE / gi;
        assign w_recip[gi] = RECIP_W'(RV);
    end

    // Pipeline valid bits and stage ready chain (stage 5 is the output).
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;

    assign w_rdy5 = !r_v5 || m_axis_tready;
    assign w_rdy4 = !r_v4 || w_rdy5;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    // Stage payload registers.
    logic [BYTE_W-1:0] r_s1_byte;
    logic [PW-1:0]     r_s1_idx, r_s2_idx, r_s3_idx, r_s4_idx;
    logic [CNT_W-1:0]  r_s1_cnt, r_s2_cnt, r_s3_cnt, r_s4_cnt;
    logic              r_s1_decay, r_s2_decay, r_s3_decay, r_s4_decay;
    logic              r_s1_pass, r_s2_pass, r_s3_pass, r_s4_pass;
    logic              r_s1_last, r_s2_last, r_s3_last, r_s4_last;
    logic [ACC_W-1:0]  r_s2_sum, r_s3_sum, r_s4_sum;
    logic [RECIP_W-1:0] r_s2_recip;
    logic [PROD_W-1:0] r_s3_prod;
    logic [ACC_W-1:0]  r_s4_q0, r_s4_qd;
    logic [BYTE_W-1:0] r_s5_data;
    logic              r_s5_last;

    // Frame position and frame count.
    logic [PW-1:0]    r_pos, n_pos;
    logic [CNT_W-1:0] r_count, n_count;

    logic [CW-1:0]    w_fb_ext;
    logic [SW-1:0]    w_size;
    logic             w_last;
    logic [CNT_W-1:0] w_cnt_used;
    logic             w_decay;
    logic             w_hazard;
    logic             w_accept;
    logic             w_clearing;
    logic [SUM_W-1:0] w_rdata;

    // Effective frame size: zero acts as one, oversize clamps to the memory depth.
    assign w_fb_ext = CW'(r_frame_bytes);
    assign w_size   = (r_frame_bytes == '0) ? SW'(1) :
                      (w_fb_ext > CW'(MAX_FRAME_BYTES)) ? SW'(MAX_FRAME_BYTES) :
                      SW'(r_frame_bytes);
    assign w_last   = (SW'(r_pos) + SW'(1)) >= w_size;

    // Count used by this byte and the decay decision.
    assign w_cnt_used = (r_pos == '0 && r_count != CNT_MAX) ? r_count + CNT_W'(1)
                                                            : r_count;
    assign w_decay    = w_cnt_used > r_max_frames;

    always_comb begin
        n_pos   = w_last ? '0 : r_pos + PW'(1);
        n_count = r_count;
        if (!r_passthrough) begin
            n_count = (w_last && w_decay) ? r_max_frames : w_cnt_used;
        end
    end

    // An in-flight write to the same position must land before the next read.
    assign w_hazard = (r_v1 && !r_s1_pass && r_s1_idx == r_pos) ||
                      (r_v2 && !r_s2_pass && r_s2_idx == r_pos) ||
                      (r_v3 && !r_s3_pass && r_s3_idx == r_pos) ||
                      (r_v4 && !r_s4_pass && r_s4_idx == r_pos);

    assign s_axis_tready = w_rdy1 && !w_clearing && !w_hazard;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_count <= CNT_W'(1);
        end else if (w_accept) begin
            r_pos   <= n_pos;
            r_count <= n_count;
        end
    end

    // Stage 4 to 5 arithmetic: quotient correction, saturation and new sum.
    logic [ACC_W-1:0]  w_rem;
    logic [ACC_W-1:0]  w_q;
    logic [BYTE_W-1:0] w_avg;
    logic [ACC_W-1:0]  w_new_acc;
    logic [SUM_W-1:0]  w_new_sum;
    logic              w_wr_en;

    always_comb begin
        w_rem     = r_s4_sum - r_s4_qd;
        w_q       = r_s4_q0 + ACC_W'(w_rem >= ACC_W'(r_s4_cnt));
        w_avg     = (w_q > ACC_W'(BYTE_MAX)) ? BYTE_MAX : w_q[BYTE_W-1:0];
        w_new_acc = r_s4_decay ? (r_s4_sum - w_q) : r_s4_sum;
        w_new_sum = (w_new_acc > ACC_W'(SUM_MAX)) ? SUM_MAX : w_new_acc[SUM_W-1:0];
    end

    assign w_wr_en = r_v4 && !r_s4_pass && w_rdy5;

    tfa_sum_store #(
        .DEPTH (MAX_FRAME_BYTES),
        .AW    (PW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (w_wr_en),
        .i_waddr    (r_s4_idx),
        .i_wdata    (w_new_sum),
        .i_re       (w_accept),
        .i_raddr    (r_pos),
        .o_rdata    (w_rdata),
        .o_clearing (w_clearing)
    );

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= w_accept;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
            if (w_rdy5) r_v5 <= r_v4;
        end
    end

    // Stage 1: capture the byte and its control; memory read is in flight.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_byte  <= s_axis_tdata;
            r_s1_idx   <= r_pos;
            r_s1_cnt   <= w_cnt_used;
            r_s1_decay <= w_decay;
            r_s1_pass  <= r_passthrough;
            r_s1_last  <= w_last;
        end
    end

    // Stage 2: add the byte to the stored sum and look up the reciprocal.
    // A passthrough byte travels on alone so that it comes out unchanged.
    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            r_s2_sum   <= r_s1_pass ? ACC_W'(r_s1_byte)
                                    : ACC_W'(w_rdata) + ACC_W'(r_s1_byte);
            r_s2_recip <= w_recip[r_s1_cnt];
            r_s2_idx   <= r_s1_idx;
            r_s2_cnt   <= r_s1_cnt;
            r_s2_decay <= r_s1_decay;
            r_s2_pass  <= r_s1_pass;
            r_s2_last  <= r_s1_last;
        end
    end

    // Stage 3: multiply the sum by the reciprocal.
    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r_v2) begin
            r_s3_prod  <= PROD_W'(r_s2_sum) * PROD_W'(r_s2_recip);
            r_s3_sum   <= r_s2_sum;
            r_s3_idx   <= r_s2_idx;
            r_s3_cnt   <= r_s2_cnt;
            r_s3_decay <= r_s2_decay;
            r_s3_pass  <= r_s2_pass;
            r_s3_last  <= r_s2_last;
        end
    end

    // Stage 4: estimated quotient and its product with the divisor.
    logic [ACC_W-1:0]       w_q0;
    logic [ACC_W+CNT_W-1:0] w_qd_full;

    assign w_q0      = r_s3_prod[PROD_W-2 -: ACC_W];
    assign w_qd_full = (ACC_W + CNT_W)'(w_q0) * (ACC_W + CNT_W)'(r_s3_cnt);

    always_ff @(posedge i_clk) begin
        if (w_rdy4 && r_v3) begin
            r_s4_q0    <= w_q0;
            r_s4_qd    <= w_qd_full[ACC_W-1:0];
            r_s4_sum   <= r_s3_sum;
            r_s4_idx   <= r_s3_idx;
            r_s4_cnt   <= r_s3_cnt;
            r_s4_decay <= r_s3_decay;
            r_s4_pass  <= r_s3_pass;
            r_s4_last  <= r_s3_last;
        end
    end

    // Stage 5: output register.
    always_ff @(posedge i_clk) begin
        if (w_rdy5 && r_v4) begin
            r_s5_data <= r_s4_pass ? r_s4_sum[BYTE_W-1:0] : w_avg;
            r_s5_last <= r_s4_last;
        end
    end

    assign m_axis_tvalid = r_v5;
    assign m_axis_tdata  = r_s5_data;
    assign m_axis_tlast  = r_s5_last;

    // Write-back never competes with the clearing sweep.
    `TFA_ASSERT_IMPLY(a_no_wr_while_clear, i_clk, i_rst_n, w_wr_en, !w_clearing)
    // A read and a write-back in the same cycle never touch the same entry.
    `TFA_ASSERT_IMPLY(a_no_rw_collision, i_clk, i_rst_n, w_wr_en && w_accept,
                      r_s4_idx != r_pos)
    // The count is back at or below the cap after a frame ends.
    `TFA_ASSERT_NEXT(a_count_capped, i_clk, i_rst_n,
                     w_accept && w_last && !r_passthrough && !i_cfg_we,
                     r_count <= r_max_frames)

endmodule

`default_nettype wire

@@ design/tfa_sum_store.sv @@
`default_nettype none

module tfa_sum_store
    import tfa_pkg::*;
#(
    parameter int DEPTH = 1048576,
    parameter int AW    = 20
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [SUM_W-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [SUM_W-1:0] o_rdata,
    output logic                  o_clearing
);

    logic [SUM_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_clr_addr;
    logic             r_clearing;

    // Clearing sweep after reset: one entry per cycle, last entry ends it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clearing <= 1'b1;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Single write port shared by the sweep and the pipeline write-back.
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

    assign o_clearing = r_clearing;

endmodule

`default_nettype wire
